### rtl/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and character constants for the CSV field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

   // width of a code unit on the ports
   localparam int CHAR_W = 16;

   // delimiter characters
   localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;
   localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
   localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
   localparam logic [CHAR_W-1:0] CH_QUOTE = 16'h0022;

   // event kinds of a result beat
   typedef enum logic [1:0] {
      EV_DATA   = 2'd0,
      EV_FIELD  = 2'd1,
      EV_RECORD = 2'd2,
      EV_ERROR  = 2'd3
   } ev_kind_type;

   // parser phase, one-hot
   typedef enum logic [5:0] {
      PH_RECORD   = 6'b000001,
      PH_FIELD    = 6'b000010,
      PH_UNQUOTED = 6'b000100,
      PH_QUOTED   = 6'b001000,
      PH_QSEEN    = 6'b010000,
      PH_ERROR    = 6'b100000
   } phase_type;

   // one result beat
   typedef struct packed {
      ev_kind_type       kind;
      logic [CHAR_W-1:0] ch;
      logic              quoted;
      logic              last;
   } rsp_item_type;

   // build a result beat, last flag cleared
   function automatic rsp_item_type make_res(ev_kind_type kind, logic [CHAR_W-1:0] ch,
                                             logic quoted);
      rsp_item_type r;
      r.kind   = kind;
      r.ch     = ch;
      r.quoted = quoted;
      r.last   = 1'b0;
      return r;
   endfunction

endpackage

### rtl/csv_field_tokenizer_top.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_top
// Streaming CSV tokenizer: one code unit in, field characters and field,
// record and error events out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_char_code, req_end_of_stream
//  rsp     | out       | rsp_valid/rsp_stall | rsp_event_kind, rsp_out_char,
//          |           |                     | rsp_was_quoted, rsp_last_of_run
//
//  one input beat per cycle while req_stall is low; an input beat producing two
//  results fills both entries of the two-slot buffer that the single rsp port drains
//  a req beat passes the input register, then the output buffer, before its rsp beats
//  reset (synchronous) returns the parser to record start and empties buffers
//  req_stall rises only while the input register holds a beat whose results
//  do not fit the output buffer; rsp_stall holds the head result in place
// ----------------------------------------------------------------------------
module csv_field_tokenizer_top
   import cft_pkg::*;
#(
   parameter int CHAR_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic              req_end_of_stream,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_event_kind,
   output logic [CHAR_W-1:0] rsp_out_char,
   output logic              rsp_was_quoted,
   output logic              rsp_last_of_run
);

   // bits of a code unit that the parser looks at
   localparam int USED_BITS = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [USED_BITS-1:0] in_char_ff;
   logic                 in_eos_ff;
   logic                 req_accept;
   logic                 process;

   // parser state
   phase_type            phase_ff, phase_in;
   logic                 hcr_ff, hcr_in;
   logic                 quoted_ff, quoted_in;

   // results of the beat in the input register
   rsp_item_type         res_v [2];
   logic [1:0]           res_cnt;
   logic                 take_char;
   logic [CHAR_W-1:0]    cur_char;

   // output buffer, slot0 is the head
   rsp_item_type         slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic [1:0]           rem_cnt;
   logic                 pop;
   logic [2:0]           fill_after;

   assign cur_char = CHAR_W'(in_char_ff);

   // handshakes
   assign pop        = (cnt_ff != 2'd0) && !rsp_stall;
   assign rem_cnt    = cnt_ff - {1'b0, pop};
   assign fill_after = {1'b0, rem_cnt} + {1'b0, res_cnt};
   assign process    = in_valid_ff && (fill_after <= 3'd2);
   assign req_stall  = in_valid_ff && !process;
   assign req_accept = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !process);

   // parser: results and next state for the held beat
   always_comb begin
      phase_in  = phase_ff;
      hcr_in    = hcr_ff;
      quoted_in = quoted_ff;
      res_cnt   = 2'd0;
      res_v[0]  = make_res(EV_DATA, '0, 1'b0);
      res_v[1]  = make_res(EV_DATA, '0, 1'b0);
      take_char = 1'b0;

      priority if (phase_ff == PH_ERROR) begin
         take_char = 1'b0;
      end else if (in_eos_ff) begin
         // end of stream: close the open field, or report an error if it cannot be closed
         hcr_in = 1'b0;
         unique case (phase_ff)
            PH_QSEEN: begin
               if (hcr_ff) begin
                  res_v[res_cnt[0]] = make_res(EV_ERROR, '0, quoted_in);
                  res_cnt  = res_cnt + 2'd1;
                  phase_in = PH_ERROR;
               end else begin
                  res_v[res_cnt[0]] = make_res(EV_RECORD, '0, quoted_in);
                  res_cnt   = res_cnt + 2'd1;
                  quoted_in = 1'b0;
                  phase_in  = PH_RECORD;
               end
            end
            PH_QUOTED: begin
               if (hcr_ff) begin
                  res_v[res_cnt[0]] = make_res(EV_DATA, CH_CR, quoted_in);
                  res_cnt = res_cnt + 2'd1;
               end
               res_v[res_cnt[0]] = make_res(EV_ERROR, '0, quoted_in);
               res_cnt  = res_cnt + 2'd1;
               phase_in = PH_ERROR;
            end
            PH_UNQUOTED, PH_FIELD: begin
               if (hcr_ff) begin
                  res_v[res_cnt[0]] = make_res(EV_DATA, CH_CR, quoted_in);
                  res_cnt = res_cnt + 2'd1;
               end
               res_v[res_cnt[0]] = make_res(EV_RECORD, '0, quoted_in);
               res_cnt   = res_cnt + 2'd1;
               quoted_in = 1'b0;
               phase_in  = PH_RECORD;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (phase_in != PH_ERROR) begin
            phase_in  = PH_RECORD;
            quoted_in = 1'b0;
         end
      end else if (hcr_ff) begin
         // a held CR meets the next character
         hcr_in = 1'b0;
         priority if (phase_ff == PH_QSEEN) begin
            if (cur_char == CHAR_W'(CH_LF[USED_BITS-1:0])) begin
               res_v[res_cnt[0]] = make_res(EV_RECORD, '0, quoted_in);
               res_cnt   = res_cnt + 2'd1;
               quoted_in = 1'b0;
               phase_in  = PH_RECORD;
            end else begin
               res_v[res_cnt[0]] = make_res(EV_ERROR, '0, quoted_in);
               res_cnt  = res_cnt + 2'd1;
               phase_in = PH_ERROR;
            end
         end else if (cur_char == CHAR_W'(CH_LF[USED_BITS-1:0])) begin
            if (phase_ff == PH_QUOTED) begin
               res_v[res_cnt[0]] = make_res(EV_DATA, CH_LF, quoted_in);
               res_cnt = res_cnt + 2'd1;
            end else begin
               res_v[res_cnt[0]] = make_res(EV_RECORD, '0, quoted_in);
               res_cnt   = res_cnt + 2'd1;
               quoted_in = 1'b0;
               phase_in  = PH_RECORD;
            end
         end else begin
            // lone CR is data, then the character goes through as usual
            res_v[res_cnt[0]] = make_res(EV_DATA, CH_CR, quoted_in);
            res_cnt   = res_cnt + 2'd1;
            take_char = 1'b1;
         end
      end else begin
         take_char = 1'b1;
      end

      // ordinary character handling
      if (take_char) begin
         unique case (phase_ff)
            PH_RECORD, PH_FIELD: begin
               quoted_in = 1'b0;
               priority if (cur_char == CHAR_W'(CH_COMMA[USED_BITS-1:0])) begin
                  res_v[res_cnt[0]] = make_res(EV_FIELD, '0, quoted_in);
                  res_cnt  = res_cnt + 2'd1;
                  phase_in = PH_FIELD;
               end else if (cur_char == CHAR_W'(CH_LF[USED_BITS-1:0])) begin
                  res_v[res_cnt[0]] = make_res(EV_RECORD, '0, quoted_in);
                  res_cnt  = res_cnt + 2'd1;
                  phase_in = PH_RECORD;
               end else if (cur_char == CHAR_W'(CH_QUOTE[USED_BITS-1:0])) begin
                  quoted_in = 1'b1;
                  phase_in  = PH_QUOTED;
               end else if (cur_char == CHAR_W'(CH_CR[USED_BITS-1:0])) begin
                  hcr_in   = 1'b1;
                  phase_in = PH_UNQUOTED;
               end else begin
                  res_v[res_cnt[0]] = make_res(EV_DATA, cur_char, quoted_in);
                  res_cnt  = res_cnt + 2'd1;
                  phase_in = PH_UNQUOTED;
               end
            end
            PH_UNQUOTED: begin
               priority if (cur_char == CHAR_W'(CH_COMMA[USED_BITS-1:0])) begin
                  res_v[res_cnt[0]] = make_res(EV_FIELD, '0, quoted_in);
                  res_cnt   = res_cnt + 2'd1;
                  quoted_in = 1'b0;
                  phase_in  = PH_FIELD;
               end else if (cur_char == CHAR_W'(CH_LF[USED_BITS-1:0])) begin
                  res_v[res_cnt[0]] = make_res(EV_RECORD, '0, quoted_in);
                  res_cnt   = res_cnt + 2'd1;
                  quoted_in = 1'b0;
                  phase_in  = PH_RECORD;
               end else if (cur_char == CHAR_W'(CH_QUOTE[USED_BITS-1:0])) begin
                  res_v[res_cnt[0]] = make_res(EV_ERROR, '0, quoted_in);
                  res_cnt  = res_cnt + 2'd1;
                  phase_in = PH_ERROR;
                  hcr_in   = 1'b0;
               end else if (cur_char == CHAR_W'(CH_CR[USED_BITS-1:0])) begin
                  hcr_in = 1'b1;
               end else begin
                  res_v[res_cnt[0]] = make_res(EV_DATA, cur_char, quoted_in);
                  res_cnt = res_cnt + 2'd1;
               end
            end
            PH_QUOTED: begin
               priority if (cur_char == CHAR_W'(CH_QUOTE[USED_BITS-1:0])) begin
                  phase_in = PH_QSEEN;
               end else if (cur_char == CHAR_W'(CH_CR[USED_BITS-1:0])) begin
                  hcr_in = 1'b1;
               end else begin
                  res_v[res_cnt[0]] = make_res(EV_DATA, cur_char, quoted_in);
                  res_cnt = res_cnt + 2'd1;
               end
            end
            PH_QSEEN: begin
               priority if (cur_char == CHAR_W'(CH_QUOTE[USED_BITS-1:0])) begin
                  // doubled quote yields one quote
                  res_v[res_cnt[0]] = make_res(EV_DATA, cur_char, quoted_in);
                  res_cnt  = res_cnt + 2'd1;
                  phase_in = PH_QUOTED;
               end else if (cur_char == CHAR_W'(CH_COMMA[USED_BITS-1:0])) begin
                  res_v[res_cnt[0]] = make_res(EV_FIELD, '0, quoted_in);
                  res_cnt   = res_cnt + 2'd1;
                  quoted_in = 1'b0;
                  phase_in  = PH_FIELD;
               end else if (cur_char == CHAR_W'(CH_LF[USED_BITS-1:0])) begin
                  res_v[res_cnt[0]] = make_res(EV_RECORD, '0, quoted_in);
                  res_cnt   = res_cnt + 2'd1;
                  quoted_in = 1'b0;
                  phase_in  = PH_RECORD;
               end else if (cur_char == CHAR_W'(CH_CR[USED_BITS-1:0])) begin
                  hcr_in = 1'b1;
               end else begin
                  res_v[res_cnt[0]] = make_res(EV_ERROR, '0, quoted_in);
                  res_cnt  = res_cnt + 2'd1;
                  phase_in = PH_ERROR;
                  hcr_in   = 1'b0;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      // mark the final result of the beat
      if (res_cnt != 2'd0) begin
         res_v[~res_cnt[0]].last = 1'b1;
      end
   end

   // output buffer update: drop the head on pop, then append new results
   always_comb begin
      if (rem_cnt != 2'd0) begin
         slot0_in = pop ? slot1_ff : slot0_ff;
      end else begin
         slot0_in = res_v[0];
      end
      unique case (rem_cnt)
         2'd2:    slot1_in = slot1_ff;
         2'd1:    slot1_in = res_v[0];
         default: slot1_in = res_v[1];
      endcase
      cnt_in = process ? fill_after[1:0] : rem_cnt;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_RECORD;
         hcr_ff      <= 1'b0;
         quoted_ff   <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         if (process) begin
            phase_ff  <= phase_in;
            hcr_ff    <= hcr_in;
            quoted_ff <= quoted_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_char_code[USED_BITS-1:0];
         in_eos_ff  <= req_end_of_stream;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // result port
   assign rsp_valid       = (cnt_ff != 2'd0);
   assign rsp_event_kind  = slot0_ff.kind;
   assign rsp_out_char    = slot0_ff.ch;
   assign rsp_was_quoted  = slot0_ff.quoted;
   assign rsp_last_of_run = slot0_ff.last;

`ifndef SYNTHESIS
   // buffer never holds more than two results
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("output buffer overfilled");

   // phase stays one-hot
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("parser phase not one-hot");

   // a held CR only exists inside a field
   a_hcr_phase: assert property (@(posedge clock) disable iff (reset)
      hcr_ff |-> (phase_ff == PH_UNQUOTED || phase_ff == PH_QUOTED ||
                  phase_ff == PH_QSEEN))
      else $error("carriage return held outside a field");

   // quoted flag only inside a quoted field or after an error
   a_quoted_phase: assert property (@(posedge clock) disable iff (reset)
      quoted_ff |-> (phase_ff == PH_QUOTED || phase_ff == PH_QSEEN ||
                     phase_ff == PH_ERROR))
      else $error("quoted flag outside a quoted field");

   // once in error no further beat adds results
   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERROR && !pop) |=> (cnt_ff == $past(cnt_ff)))
      else $error("result produced after error");
`endif

endmodule
